/* sv/clr_pkg.sv */
package clr_pkg;

    // coordinate and field widths
    localparam int COORD_W  = 8;
    localparam int PIXEL_W  = 6;
    localparam int COLOR_W  = 8;
    localparam int SIZE_W   = 7;
    localparam int WALK_W   = COORD_W + 1;
    localparam int ERR_W    = COORD_W + 3;

    // canvas limit, also the reach of the pixel coordinates
    localparam int CANVAS_MAX = 64;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(CANVAS_MAX);

    // configuration register indexes
    localparam logic CFG_CANVAS_WIDTH  = 1'b0;
    localparam logic CFG_CANVAS_HEIGHT = 1'b1;

    // one walk step offered by the walker to the output stage
    typedef struct packed {
        logic               active;
        logic               pix;
        logic               fin;
        logic [PIXEL_W-1:0] x;
        logic [PIXEL_W-1:0] y;
        logic [COLOR_W-1:0] color;
    } walk_t;

    // clamp a canvas register to the usable size
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = (v > SIZE_W'(CANVAS_MAX)) ? SIZE_W'(CANVAS_MAX) : v;
        return r;
    endfunction

endpackage

/* sv/clr_line_if.sv */
interface clr_line_if;
    logic                                valid;
    logic                                ready;
    logic signed [clr_pkg::COORD_W-1:0]  start_x;
    logic signed [clr_pkg::COORD_W-1:0]  start_y;
    logic signed [clr_pkg::COORD_W-1:0]  end_x;
    logic signed [clr_pkg::COORD_W-1:0]  end_y;
    logic        [clr_pkg::COLOR_W-1:0]  line_color;

    modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

/* sv/clr_pixel_if.sv */
interface clr_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [clr_pkg::PIXEL_W-1:0]  pixel_x;
    logic [clr_pkg::PIXEL_W-1:0]  pixel_y;
    logic [clr_pkg::COLOR_W-1:0]  pixel_color;
    logic                         last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

/* sv/clr_walker.sv */
module clr_walker (
    input  logic                          clk,
    input  logic                          rst_n,
    clr_line_if.sink                      cmd,
    input  logic [clr_pkg::SIZE_W-1:0]    canvas_w,
    input  logic [clr_pkg::SIZE_W-1:0]    canvas_h,
    output clr_pkg::walk_t                ev,
    input  logic                          take
);

    localparam int CW = clr_pkg::COORD_W;
    localparam int WW = clr_pkg::WALK_W;
    localparam int EW = clr_pkg::ERR_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIFF = 2'd1;
    localparam logic [1:0] ST_INIT = 2'd2;
    localparam logic [1:0] ST_WALK = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic signed [CW-1:0]        x0_reg, y0_reg, x1_reg, y1_reg;
    logic [clr_pkg::COLOR_W-1:0] color_reg;
    logic signed [WW-1:0]        dx_reg, dy_reg;
    logic [CW-1:0]               adx_reg, ady_reg;
    logic                        steep_reg, up_reg;
    logic signed [WW-1:0]        maj_reg, mnr_reg, stop_reg;
    logic signed [WW-1:0]        maj_next, mnr_next, stop_next;
    logic signed [EW-1:0]        e_reg, e_next;
    logic signed [EW-1:0]        inc_a_reg, inc_b_reg;

    logic signed [WW-1:0]        dx_c, dy_c;
    logic [CW-1:0]               adx_c, ady_c, maj_abs, mnr_abs;
    logic                        steep_c;
    logic signed [EW-1:0]        mnr2, maj2, e_sum;
    logic signed [WW-1:0]        px, py;
    logic                        in_canvas, fin;

    assign cmd.ready = (state_reg == ST_IDLE);

    // endpoint differences and magnitudes
    always_comb
    begin
        dx_c  = WW'(x1_reg) - WW'(x0_reg);
        dy_c  = WW'(y1_reg) - WW'(y0_reg);
        adx_c = dx_c[WW-1] ? CW'(-dx_c) : dx_c[CW-1:0];
        ady_c = dy_c[WW-1] ? CW'(-dy_c) : dy_c[CW-1:0];
    end

    // major/minor split and error-term increments
    always_comb
    begin
        steep_c = (ady_reg > adx_reg);
        maj_abs = steep_c ? ady_reg : adx_reg;
        mnr_abs = steep_c ? adx_reg : ady_reg;
        mnr2    = EW'({1'b0, mnr_abs, 1'b0});
        maj2    = EW'({1'b0, maj_abs, 1'b0});
    end

    // current pixel and canvas test
    always_comb
    begin
        px  = steep_reg ? mnr_reg : maj_reg;
        py  = steep_reg ? maj_reg : mnr_reg;
        in_canvas = !px[WW-1] && !py[WW-1]
                    && ({1'b0, px[CW-1:0]} < {2'b0, canvas_w})
                    && ({1'b0, py[CW-1:0]} < {2'b0, canvas_h});
        fin = (maj_reg == stop_reg);
    end

    // shared error-term adder
    assign e_sum = e_reg + (e_reg[EW-1] ? inc_a_reg : inc_b_reg);

    always_comb
    begin
        ev.active = (state_reg == ST_WALK);
        ev.pix    = in_canvas;
        ev.fin    = fin;
        ev.x      = px[clr_pkg::PIXEL_W-1:0];
        ev.y      = py[clr_pkg::PIXEL_W-1:0];
        ev.color  = color_reg;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        maj_next   = maj_reg;
        mnr_next   = mnr_reg;
        stop_next  = stop_reg;
        e_next     = e_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                    state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                state_next = ST_WALK;
                e_next     = mnr2 - EW'({1'b0, maj_abs});
                if (!steep_c)
                begin
                    if (!dx_reg[WW-1])
                    begin
                        maj_next = WW'(x0_reg); mnr_next = WW'(y0_reg); stop_next = WW'(x1_reg);
                    end
                    else
                    begin
                        maj_next = WW'(x1_reg); mnr_next = WW'(y1_reg); stop_next = WW'(x0_reg);
                    end
                end
                else
                begin
                    if (!dy_reg[WW-1])
                    begin
                        maj_next = WW'(y0_reg); mnr_next = WW'(x0_reg); stop_next = WW'(y1_reg);
                    end
                    else
                    begin
                        maj_next = WW'(y1_reg); mnr_next = WW'(x1_reg); stop_next = WW'(y0_reg);
                    end
                end
            end
            ST_WALK:
            begin
                if (take)
                begin
                    if (fin)
                        state_next = ST_IDLE;
                    else
                    begin
                        maj_next = maj_reg + WW'(1);
                        e_next   = e_sum;
                        if (!e_reg[EW-1])
                            mnr_next = up_reg ? mnr_reg + WW'(1) : mnr_reg - WW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        maj_reg  <= maj_next;
        mnr_reg  <= mnr_next;
        stop_reg <= stop_next;
        e_reg    <= e_next;
        if (cmd.valid && cmd.ready)
        begin
            x0_reg    <= cmd.start_x;
            y0_reg    <= cmd.start_y;
            x1_reg    <= cmd.end_x;
            y1_reg    <= cmd.end_y;
            color_reg <= cmd.line_color;
        end
        if (state_reg == ST_DIFF)
        begin
            dx_reg  <= dx_c;
            dy_reg  <= dy_c;
            adx_reg <= adx_c;
            ady_reg <= ady_c;
            up_reg  <= (dx_c != '0) && (dy_c != '0) && (dx_c[WW-1] == dy_c[WW-1]);
        end
        if (state_reg == ST_INIT)
        begin
            steep_reg <= steep_c;
            inc_a_reg <= mnr2;
            inc_b_reg <= mnr2 - maj2;
        end
    end

    // checks
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (maj_reg <= stop_reg))
        else $error("major coordinate ran past the stop point");

    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && take && fin) |=> (state_reg == ST_IDLE))
        else $error("walk did not end after its final step");

    a_take_walk: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (state_reg == ST_WALK))
        else $error("step taken outside the walk");

endmodule

/* sv/clr_emit.sv */
module clr_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clr_pkg::walk_t       ev,
    output logic                 take,
    clr_pixel_if.source          pix
);

    localparam int PW = clr_pkg::PIXEL_W;
    localparam int KW = clr_pkg::COLOR_W;

    logic          pend_valid_reg, pend_valid_next;
    logic          pend_last_reg, pend_last_next;
    logic [PW-1:0] pend_x_reg, pend_y_reg;
    logic [KW-1:0] pend_color_reg;
    logic          out_valid_reg, out_valid_next;
    logic          out_last_reg;
    logic [PW-1:0] out_x_reg, out_y_reg;
    logic [KW-1:0] out_color_reg;
    logic          out_free, push;

    // the held pixel leaves once it is known whether it is the last one
    assign out_free = !out_valid_reg || pix.ready;
    assign push     = pend_valid_reg && out_free && (pend_last_reg || (ev.active && ev.pix));
    assign take     = ev.active
                      && (!pend_valid_reg || push || (!ev.pix && !pend_last_reg));

    // lookahead slot and output register control
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;
        if (push)
        begin
            pend_valid_next = 1'b0;
            pend_last_next  = 1'b0;
        end
        if (take && ev.pix)
        begin
            pend_valid_next = 1'b1;
            pend_last_next  = ev.fin;
        end
        else if (take && ev.fin && pend_valid_reg && !push)
            pend_last_next = 1'b1;

        out_valid_next = out_valid_reg;
        if (push)
            out_valid_next = 1'b1;
        else if (pix.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && ev.pix)
        begin
            pend_x_reg     <= ev.x;
            pend_y_reg     <= ev.y;
            pend_color_reg <= ev.color;
        end
        if (push)
        begin
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_color_reg <= pend_color_reg;
            out_last_reg  <= pend_last_reg;
        end
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = out_x_reg;
    assign pix.pixel_y     = out_y_reg;
    assign pix.pixel_color = out_color_reg;
    assign pix.last_pixel  = out_last_reg;

    // checks
    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        pend_last_reg |-> pend_valid_reg)
        else $error("last mark without a held pixel");

    a_push_out: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg)
        else $error("pushed pixel not presented");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("pixel pushed over a waiting transfer");

endmodule

/* sv/clipped_line_rasterizer.sv */
// Bresenham line rasterizer with canvas clipping. Each line command is taken on
// cmd and walked from the endpoint with the lower major coordinate; every pixel
// inside the canvas set by canvas_width and canvas_height (values above 64 act
// as 64, zero drops every pixel) goes out on pix with the line color, the last
// one carrying last_pixel. A command is taken in the idle state, passes
// the setup states DIFF and INIT, then is walked one pixel position per
// cycle along the major axis through the single error-term adder while
// pix does not stall; a stall on pix holds the walk. cmd.ready stays low
// until the walk ends; a one-pixel lookahead slot and an output register
// let the next command be taken while the final pixels of a line still wait.
module clipped_line_rasterizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [clr_pkg::SIZE_W-1:0]    cfg_data,
    clr_line_if.sink                      cmd,
    clr_pixel_if.source                   pix
);

    logic [clr_pkg::SIZE_W-1:0] canvas_width_reg, canvas_height_reg;
    logic [clr_pkg::SIZE_W-1:0] canvas_w, canvas_h;
    clr_pkg::walk_t             ev;
    logic                       take;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= clr_pkg::SIZE_RESET;
            canvas_height_reg <= clr_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                clr_pkg::CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data;
                clr_pkg::CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // usable canvas size
    assign canvas_w = clr_pkg::clamp_size(canvas_width_reg);
    assign canvas_h = clr_pkg::clamp_size(canvas_height_reg);

    clr_walker u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .canvas_w (canvas_w),
        .canvas_h (canvas_h),
        .ev       (ev),
        .take     (take)
    );

    clr_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .ev    (ev),
        .take  (take),
        .pix   (pix)
    );

endmodule

/* bench/clr_pixel_checker.sv */
`timescale 1ns / 100ps

module clr_pixel_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [clr_pkg::SIZE_W-1:0] cfg_data,
    clr_line_if                        cmd,
    clr_pixel_if                       pix,
    output int unsigned                pixels_owed,
    output int unsigned                mismatches
);

    typedef struct packed {
        logic [clr_pkg::PIXEL_W-1:0] x;
        logic [clr_pkg::PIXEL_W-1:0] y;
        logic [clr_pkg::COLOR_W-1:0] color;
        logic                        last;
    } canvas_pixel_t;

    // canvas size as last written
    logic [clr_pkg::SIZE_W-1:0] canvas_w;
    logic [clr_pkg::SIZE_W-1:0] canvas_h;

    // pixels still owed by the block, oldest first
    canvas_pixel_t owed_pixels[$];
    canvas_pixel_t want;
    canvas_pixel_t got;

    // walk one line from its lower major end and queue the pixels inside the canvas
    function automatic void rasterize_line(input int x0, input int y0, input int x1,
                                           input int y1,
                                           input logic [clr_pkg::COLOR_W-1:0] color);
        canvas_pixel_t run[$];
        canvas_pixel_t p;
        int w;
        int h;
        int dx;
        int dy;
        int adx;
        int ady;
        int x;
        int y;
        int e;
        int stop;
        int minor_step;
        bit steep;
        bit more;
        w = int'(canvas_w);
        h = int'(canvas_h);
        if (w > clr_pkg::CANVAS_MAX) w = clr_pkg::CANVAS_MAX;
        if (h > clr_pkg::CANVAS_MAX) h = clr_pkg::CANVAS_MAX;
        dx = x1 - x0;
        dy = y1 - y0;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        minor_step = ((dx < 0 && dy < 0) || (dx > 0 && dy > 0)) ? 1 : -1;
        steep = ady > adx;
        if (!steep)
        begin
            e = 2 * ady - adx;
            if (dx >= 0)
            begin
                x = x0;
                y = y0;
                stop = x1;
            end
            else
            begin
                x = x1;
                y = y1;
                stop = x0;
            end
        end
        else
        begin
            e = 2 * adx - ady;
            if (dy >= 0)
            begin
                x = x0;
                y = y0;
                stop = y1;
            end
            else
            begin
                x = x1;
                y = y1;
                stop = y0;
            end
        end
        more = 1'b1;
        while (more)
        begin
            // clip against the canvas
            if (x >= 0 && x < w && y >= 0 && y < h && run.size() < clr_pkg::CANVAS_MAX)
            begin
                p.x = clr_pkg::PIXEL_W'(x);
                p.y = clr_pkg::PIXEL_W'(y);
                p.color = color;
                p.last = 1'b0;
                run.push_back(p);
            end
            more = steep ? (y < stop) : (x < stop);
            if (more)
            begin
                // one major step, minor step when the error term allows
                if (steep) y++;
                else x++;
                if (e < 0)
                begin
                    e += steep ? 2 * adx : 2 * ady;
                end
                else
                begin
                    if (steep) x += minor_step;
                    else y += minor_step;
                    e += steep ? 2 * (adx - ady) : 2 * (ady - adx);
                end
            end
        end
        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        foreach (run[i]) owed_pixels.push_back(run[i]);
    endfunction

    function automatic void check_field(input string what,
                                        input logic [clr_pkg::COLOR_W-1:0] exp_val,
                                        input logic [clr_pkg::COLOR_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // follow config writes, predict accepted lines, compare pixel transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_w = clr_pkg::SIZE_RESET;
            canvas_h = clr_pkg::SIZE_RESET;
            owed_pixels.delete();
            mismatches = 0;
            pixels_owed <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == clr_pkg::CFG_CANVAS_WIDTH) canvas_w = cfg_data;
                else canvas_h = cfg_data;
            end
            if (cmd.valid && cmd.ready)
                rasterize_line(int'(cmd.start_x), int'(cmd.start_y), int'(cmd.end_x),
                               int'(cmd.end_y), cmd.line_color);
            if (pix.valid && pix.ready)
            begin
                got.x = pix.pixel_x;
                got.y = pix.pixel_y;
                got.color = pix.pixel_color;
                got.last = pix.last_pixel;
                if (owed_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel x=%0d y=%0d color=%0d last=%0d",
                             $time, got.x, got.y, got.color, got.last);
                    mismatches++;
                end
                else
                begin
                    want = owed_pixels.pop_front();
                    check_field("pixel_x", clr_pkg::COLOR_W'(want.x),
                                clr_pkg::COLOR_W'(got.x));
                    check_field("pixel_y", clr_pkg::COLOR_W'(want.y),
                                clr_pkg::COLOR_W'(got.y));
                    check_field("pixel_color", want.color, got.color);
                    check_field("last_pixel", clr_pkg::COLOR_W'(want.last),
                                clr_pkg::COLOR_W'(got.last));
                end
            end
            pixels_owed <= owed_pixels.size();
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int QUIET_LIMIT  = 5000;
    localparam int WALK_CYCLES  = 300;
    localparam int SEGMENTS     = 7;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic                       cfg_index;
    logic [clr_pkg::SIZE_W-1:0] cfg_data;

    int unsigned pixels_owed;
    int unsigned mismatches;

    int send_idle;
    int recv_idle;
    int stall_req;
    int hold_left;
    int quiet_cycles;
    int canvas_w;
    int canvas_h;

    // per segment: canvas size, idle percentages and number of random lines
    int seg_width  [SEGMENTS] = '{64, 1, 127, 0, 64, 37, 0};
    int seg_height [SEGMENTS] = '{64, 1, 100, 127, 0, 13, 0};
    int seg_send   [SEGMENTS] = '{11, 11, 86, 86, 0, 0, 0};
    int seg_recv   [SEGMENTS] = '{86, 86, 11, 11, 0, 0, 0};
    int seg_lines  [SEGMENTS] = '{90, 40, 100, 15, 15, 100, 120};

    clr_line_if  line_ch ();
    clr_pixel_if pixel_ch ();

    clipped_line_rasterizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (line_ch),
        .pix       (pixel_ch)
    );

    clr_pixel_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (line_ch),
        .pix         (pixel_ch),
        .pixels_owed (pixels_owed),
        .mismatches  (mismatches)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // offer one line and return at the edge where it is taken
    task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                             input int color);
        if ($urandom_range(99) < send_idle)
        begin
            line_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        line_ch.valid      <= 1'b1;
        line_ch.start_x    <= clr_pkg::COORD_W'(sx);
        line_ch.start_y    <= clr_pkg::COORD_W'(sy);
        line_ch.end_x      <= clr_pkg::COORD_W'(ex);
        line_ch.end_y      <= clr_pkg::COORD_W'(ey);
        line_ch.line_color <= clr_pkg::COLOR_W'(color);
        @(posedge clk);
        while (!line_ch.ready) @(posedge clk);
    endtask

    // stop offering and wait for every owed pixel
    task automatic wait_drained();
        line_ch.valid <= 1'b0;
        @(posedge clk);
        while (pixels_owed != 0) @(posedge clk);
    endtask

    task automatic write_canvas(input int w, input int h);
        cfg_we    <= 1'b1;
        cfg_index <= clr_pkg::CFG_CANVAS_WIDTH;
        cfg_data  <= clr_pkg::SIZE_W'(w);
        @(posedge clk);
        cfg_index <= clr_pkg::CFG_CANVAS_HEIGHT;
        cfg_data  <= clr_pkg::SIZE_W'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int edge_coord();
        case ($urandom_range(5))
            0: return -128;
            1: return 127;
            2: return 0;
            3: return 63;
            4: return 64;
            default: return -1;
        endcase
    endfunction

    // mostly lines near the canvas, some across the whole coordinate range
    task automatic random_line();
        int sx;
        int sy;
        int ex;
        int ey;
        int d;
        int kind;
        kind = $urandom_range(99);
        sx = $urandom_range(83) - 10;
        sy = $urandom_range(83) - 10;
        if (kind < 45)
        begin
            ex = $urandom_range(83) - 10;
            ey = $urandom_range(83) - 10;
        end
        else if (kind < 65)
        begin
            sx = $urandom_range(255) - 128;
            sy = $urandom_range(255) - 128;
            ex = $urandom_range(255) - 128;
            ey = $urandom_range(255) - 128;
        end
        else if (kind < 80)
        begin
            ex = sx + $urandom_range(16) - 8;
            ey = sy + $urandom_range(16) - 8;
        end
        else if (kind < 92)
        begin
            d = $urandom_range(40) - 20;
            case ($urandom_range(3))
                0:
                begin
                    ex = sx + d;
                    ey = sy;
                end
                1:
                begin
                    ex = sx;
                    ey = sy + d;
                end
                2:
                begin
                    ex = sx + d;
                    ey = $urandom_range(1) ? sy + d : sy - d;
                end
                default:
                begin
                    ex = sx;
                    ey = sy;
                end
            endcase
        end
        else
        begin
            sx = edge_coord();
            sy = edge_coord();
            ex = edge_coord();
            ey = edge_coord();
        end
        send_line(sx, sy, ex, ey, $urandom_range(255));
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        pixel_ch.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_req > 0)
            begin
                hold_left = stall_req;
                stall_req = 0;
            end
            if (hold_left > 0)
            begin
                pixel_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                pixel_ch.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((line_ch.valid && line_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = clr_pkg::CFG_CANVAS_WIDTH;
        cfg_data           = '0;
        line_ch.valid      = 1'b0;
        line_ch.start_x    = '0;
        line_ch.start_y    = '0;
        line_ch.end_x      = '0;
        line_ch.end_y      = '0;
        line_ch.line_color = '0;
        send_idle          = seg_send[0];
        recv_idle          = seg_recv[0];
        stall_req          = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int s = 0; s < SEGMENTS; s++)
        begin
            // reconfigure only once the block has gone idle
            if (s > 0)
            begin
                wait_drained();
                repeat (WALK_CYCLES) @(posedge clk);
            end
            send_idle = seg_send[s];
            recv_idle = seg_recv[s];
            canvas_w = seg_width[s];
            canvas_h = seg_height[s];
            if (s == SEGMENTS - 1)
            begin
                canvas_w = $urandom_range(64, 1);
                canvas_h = $urandom_range(64, 1);
            end
            write_canvas(canvas_w, canvas_h);

            if (s == 0)
            begin
                // single points inside, outside and at the far corner
                send_line(10, 10, 10, 10, 0);
                send_line(-1, 5, -1, 5, 255);
                send_line(63, 63, 63, 63, 170);
                send_line(64, 64, 64, 64, 85);
                // full-width horizontal and full-height vertical
                send_line(0, 0, 63, 0, 1);
                send_line(5, -128, 5, 127, 254);
                // diagonals, equal deltas
                send_line(0, 0, 63, 63, 2);
                send_line(63, 0, 0, 63, 3);
                send_line(0, 10, 10, 0, 4);
                // coordinate extremes, the first walked in reverse
                send_line(127, 127, -128, -128, 128);
                send_line(-128, 127, 127, -128, 127);
                // shallow with negative dx, steep both ways, shallow with positive dx
                send_line(50, 20, 3, 31, 5);
                send_line(3, 2, 9, 60, 6);
                send_line(40, 60, 30, 1, 7);
                send_line(20, 5, 40, 24, 8);
                // wholly outside: left/above and to the right
                send_line(-100, -100, -10, -50, 9);
                send_line(70, 0, 127, 10, 10);
                // enters and leaves the canvas
                send_line(-20, 10, 80, 30, 11);
                send_line(30, -40, 10, 100, 12);
            end

            for (int i = 0; i < seg_lines[s]; i++)
            begin
                // long receiver hold-off while lines keep coming
                if (s == 5 && i == 10) stall_req = 400;
                // full pause of the sender until the block has emptied
                if (s == SEGMENTS - 1 && i == 60) wait_drained();
                random_line();
            end
        end

        wait_drained();
        repeat (WALK_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
